// ===== rtl/box_blur_3x3_edge_aware_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the box blur block
// Shared property forms used by the RTL checks of this block.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_EDGE_AWARE_DEFINES_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("box blur check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BBE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("box blur check failed");

`endif

// ===== rtl/bbe_pkg.sv =====
// ----------------------------------------------------------------------------
// Box blur package
// Widths, codes, control structs and the reciprocal table of the blur.
// ----------------------------------------------------------------------------
`default_nettype none
package bbe_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int COL_W       = 11;
    localparam int ROW_W       = 16;
    localparam int PIX_W       = 8;
    localparam int RGB_W       = 3 * PIX_W;
    localparam int CFG_W       = 16;
    localparam int COLSUM_W    = 10;
    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int X_W         = 13;
    localparam int RECIP_W     = 18;
    localparam int RECIP_SHIFT = 18;
    localparam int PROD_W      = X_W + RECIP_W;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = FIFO_PTR_W + 1;

    typedef enum logic {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_DRAIN = 1'b1
    } t_cmd;

    typedef struct packed {
        logic             pix;
        logic             drn;
        logic             emit_a;
        logic             emit_b;
        logic             last_a;
        logic             use_top;
        logic             use_bot;
        logic             c_ge1;
        logic             c_ge2;
        logic             cap0;
        logic             d_first;
        logic             d_ge1;
        logic             d_next;
        logic             hge2;
        logic [CNT_W-1:0] n_a;
        logic [CNT_W-1:0] n_b;
    } t_ctl;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             frame_end;
    } t_res;

    // ceil(2^18 / (2*n)) for the pixel counts that can occur.
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] m;
        begin
            case (n)
                4'd1:    m = 18'd131072;
                4'd2:    m = 18'd65536;
                4'd3:    m = 18'd43691;
                4'd4:    m = 18'd32768;
                4'd6:    m = 18'd21846;
                4'd9:    m = 18'd14564;
                default: m = '0;
            endcase
            return m;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/bbe_if.sv =====
// ----------------------------------------------------------------------------
// Box blur stream interfaces
// Valid/ready channels for input words and blurred result words.
// ----------------------------------------------------------------------------
`default_nettype none
interface bbe_in_if;
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic [bbe_pkg::PIX_W-1:0] in_red;
    logic [bbe_pkg::PIX_W-1:0] in_green;
    logic [bbe_pkg::PIX_W-1:0] in_blue;

    modport source (output valid, cmd, in_red, in_green, in_blue, input ready);
    modport sink   (input valid, cmd, in_red, in_green, in_blue, output ready);
endinterface

interface bbe_out_if;
    logic                      valid;
    logic                      ready;
    logic [bbe_pkg::PIX_W-1:0] out_red;
    logic [bbe_pkg::PIX_W-1:0] out_green;
    logic [bbe_pkg::PIX_W-1:0] out_blue;
    logic                      frame_end;

    modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/bbe_line_ram.sv =====
// ----------------------------------------------------------------------------
// Box blur line RAM
// One image row of RGB words, read-first, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module bbe_line_ram (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [bbe_pkg::ADDR_W-1:0] i_addr,
    input  wire logic [bbe_pkg::RGB_W-1:0]  i_wdata,
    output logic      [bbe_pkg::RGB_W-1:0]  o_rdata
);

    logic [bbe_pkg::RGB_W-1:0] r_mem [bbe_pkg::MAX_WIDTH];

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_addr];
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/bbe_lane.sv =====
// ----------------------------------------------------------------------------
// Box blur channel lane
// Column sums, window sums and rounded mean for one color channel.
// ----------------------------------------------------------------------------
`default_nettype none
module bbe_lane (
    input  wire logic                      i_clk,
    input  wire bbe_pkg::t_ctl             i_ctl_b,
    input  wire bbe_pkg::t_ctl             i_ctl_c,
    input  wire logic [bbe_pkg::PIX_W-1:0] i_top,
    input  wire logic [bbe_pkg::PIX_W-1:0] i_mid,
    input  wire logic [bbe_pkg::PIX_W-1:0] i_bot,
    output logic      [bbe_pkg::PIX_W-1:0] o_mean_a,
    output logic      [bbe_pkg::PIX_W-1:0] o_mean_b
);

    logic [bbe_pkg::COLSUM_W-1:0] col;
    logic [bbe_pkg::COLSUM_W-1:0] cur_d;
    logic [bbe_pkg::COLSUM_W-1:0] cap_val;
    logic [bbe_pkg::SUM_W-1:0]    n_sa;
    logic [bbe_pkg::SUM_W-1:0]    n_sb;
    logic [bbe_pkg::X_W-1:0]      x_a;
    logic [bbe_pkg::X_W-1:0]      x_b;

    logic [bbe_pkg::COLSUM_W-1:0] r_w1;
    logic [bbe_pkg::COLSUM_W-1:0] r_w2;
    logic [bbe_pkg::COLSUM_W-1:0] r_cap0;
    logic [bbe_pkg::COLSUM_W-1:0] r_dprev;
    logic [bbe_pkg::COLSUM_W-1:0] r_dcur;
    logic [bbe_pkg::SUM_W-1:0]    r_sa;
    logic [bbe_pkg::SUM_W-1:0]    r_sb;
    logic [bbe_pkg::PROD_W-1:0]   r_prod_a;
    logic [bbe_pkg::PROD_W-1:0]   r_prod_b;

    always_comb begin
        col = (i_ctl_b.use_top ? bbe_pkg::COLSUM_W'(i_top) : '0)
            + bbe_pkg::COLSUM_W'(i_mid)
            + (i_ctl_b.use_bot ? bbe_pkg::COLSUM_W'(i_bot) : '0);
        cap_val = (i_ctl_b.hge2 ? bbe_pkg::COLSUM_W'(i_mid) : '0)
                + bbe_pkg::COLSUM_W'(i_bot);
        cur_d = i_ctl_b.d_first ? r_cap0 : r_dcur;
        if (i_ctl_b.drn) begin
            n_sa = (i_ctl_b.d_ge1 ? bbe_pkg::SUM_W'(r_dprev) : '0)
                 + bbe_pkg::SUM_W'(cur_d)
                 + (i_ctl_b.d_next ? bbe_pkg::SUM_W'(col) : '0);
        end else begin
            n_sa = bbe_pkg::SUM_W'(col) + bbe_pkg::SUM_W'(r_w1)
                 + (i_ctl_b.c_ge2 ? bbe_pkg::SUM_W'(r_w2) : '0);
        end
        n_sb = bbe_pkg::SUM_W'(col) + (i_ctl_b.c_ge1 ? bbe_pkg::SUM_W'(r_w1) : '0);
    end

    // Rounded mean: (2*sum + n) / (2*n) by reciprocal multiplication.
    always_comb begin
        x_a = {r_sa, 1'b0} + bbe_pkg::X_W'(i_ctl_c.n_a);
        x_b = {r_sb, 1'b0} + bbe_pkg::X_W'(i_ctl_c.n_b);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl_b.pix) begin
            r_w2 <= r_w1;
            r_w1 <= col;
            if (i_ctl_b.cap0) begin
                r_cap0 <= cap_val;
            end
        end
        if (i_ctl_b.drn) begin
            r_dprev <= cur_d;
            r_dcur  <= col;
        end
        r_sa     <= n_sa;
        r_sb     <= n_sb;
        r_prod_a <= bbe_pkg::PROD_W'(x_a) * bbe_pkg::PROD_W'(bbe_pkg::recip(i_ctl_c.n_a));
        r_prod_b <= bbe_pkg::PROD_W'(x_b) * bbe_pkg::PROD_W'(bbe_pkg::recip(i_ctl_c.n_b));
    end

    assign o_mean_a = r_prod_a[bbe_pkg::RECIP_SHIFT +: bbe_pkg::PIX_W];
    assign o_mean_b = r_prod_b[bbe_pkg::RECIP_SHIFT +: bbe_pkg::PIX_W];

endmodule
`default_nettype wire

// ===== rtl/bbe_out_fifo.sv =====
// ----------------------------------------------------------------------------
// Box blur result queue
// Merges up to two lane results per cycle; one word out per cycle when ready.
// ----------------------------------------------------------------------------
`default_nettype none
module bbe_out_fifo (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_push_a,
    input  wire bbe_pkg::t_res                  i_data_a,
    input  wire logic                           i_push_b,
    input  wire bbe_pkg::t_res                  i_data_b,
    output logic      [bbe_pkg::FIFO_CNT_W-1:0] o_count,
    bbe_out_if.source                           o_pix
);

    bbe_pkg::t_res                  r_mem [bbe_pkg::FIFO_DEPTH];
    logic [bbe_pkg::FIFO_PTR_W-1:0] r_wp;
    logic [bbe_pkg::FIFO_PTR_W-1:0] r_rp;
    logic [bbe_pkg::FIFO_CNT_W-1:0] r_cnt;
    logic [bbe_pkg::FIFO_PTR_W-1:0] wp_b;
    logic                           pop;

    assign pop  = o_pix.valid & o_pix.ready;
    assign wp_b = i_push_a ? r_wp + 1'b1 : r_wp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + bbe_pkg::FIFO_PTR_W'(i_push_a) + bbe_pkg::FIFO_PTR_W'(i_push_b);
            r_rp  <= r_rp + bbe_pkg::FIFO_PTR_W'(pop);
            r_cnt <= r_cnt + bbe_pkg::FIFO_CNT_W'(i_push_a) + bbe_pkg::FIFO_CNT_W'(i_push_b)
                   - bbe_pkg::FIFO_CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_a) begin
            r_mem[r_wp] <= i_data_a;
        end
        if (i_push_b) begin
            r_mem[wp_b] <= i_data_b;
        end
    end

    assign o_count         = r_cnt;
    assign o_pix.valid     = (r_cnt != '0);
    assign o_pix.out_red   = r_mem[r_rp].red;
    assign o_pix.out_green = r_mem[r_rp].green;
    assign o_pix.out_blue  = r_mem[r_rp].blue;
    assign o_pix.frame_end = r_mem[r_rp].frame_end;

endmodule
`default_nettype wire

// ===== rtl/box_blur_3x3_edge_aware.sv =====
// ----------------------------------------------------------------------------
// Edge-aware 3x3 box blur, top level
// Streaming RGB blur with two line RAMs, three channel lanes and a result queue.
// ----------------------------------------------------------------------------
// The block takes one word per clock: a pixel (cmd = 0) in raster order or a
// drain tick (cmd = 1). Each result is the mean of the 3x3 neighborhood that
// lies inside the frame, rounded half up. The result for row r-1, column c-1
// leaves with the pixel of row r, column c; the last pixel of a row also gives
// the result of the row's last column, so a row end yields two words if the
// width exceeds one. Row 0 gives nothing, and once the frame is in, one drain
// tick per column emits the last row, with frame_end on its final word. The
// rate is one word per clock, set by the single read/write port of the line
// RAMs, and the input waits only while the eight-entry result queue cannot
// hold every result already in flight. Writing either size register restarts
// the frame; the line RAMs keep their contents.
`default_nettype none
`include "box_blur_3x3_edge_aware_defines.svh"
module box_blur_3x3_edge_aware (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_idx,
    input  wire logic [bbe_pkg::CFG_W-1:0] i_cfg_data,
    bbe_in_if.sink                         i_pix,
    bbe_out_if.source                      o_pix
);

    logic [bbe_pkg::COL_W-1:0] r_fw;
    logic [bbe_pkg::ROW_W-1:0] r_fh;
    logic [bbe_pkg::COL_W-1:0] r_col;
    logic [bbe_pkg::ROW_W-1:0] r_row;
    logic [bbe_pkg::COL_W-1:0] r_drn;
    logic [bbe_pkg::COL_W-1:0] n_col;
    logic [bbe_pkg::ROW_W-1:0] n_row;
    logic [bbe_pkg::COL_W-1:0] n_drn;

    logic [bbe_pkg::COL_W-1:0] w_eff;
    logic [bbe_pkg::ROW_W-1:0] h_eff;
    logic [bbe_pkg::COL_W-1:0] col_inc;
    logic [bbe_pkg::COL_W-1:0] drn_inc;

    logic accept;
    logic is_drain;
    logic pix_ok;
    logic drn_ok;
    logic [1:0] rows_p;
    logic [1:0] cols_a;
    logic [1:0] cols_b;
    logic [1:0] cols_d;
    logic [1:0] rows_d;

    bbe_pkg::t_ctl n_ctl;
    bbe_pkg::t_ctl r_ctl_b;
    bbe_pkg::t_ctl r_ctl_c;
    bbe_pkg::t_ctl r_ctl_d;

    logic [bbe_pkg::ADDR_W-1:0] ram_addr;
    logic [bbe_pkg::RGB_W-1:0]  pix_in;
    logic [bbe_pkg::RGB_W-1:0]  rd0;
    logic [bbe_pkg::RGB_W-1:0]  rd1;
    logic [bbe_pkg::RGB_W-1:0]  top_b;
    logic [bbe_pkg::RGB_W-1:0]  mid_b;
    logic [bbe_pkg::RGB_W-1:0]  r_bot_b;
    logic                       r_sel_b;

    logic [bbe_pkg::PIX_W-1:0]      mean_a [3];
    logic [bbe_pkg::PIX_W-1:0]      mean_b [3];
    bbe_pkg::t_res                  res_a;
    bbe_pkg::t_res                  res_b;
    logic [bbe_pkg::FIFO_CNT_W-1:0] fifo_cnt;
    logic [bbe_pkg::FIFO_CNT_W:0]   reserved;

    // Effective frame size: a zero width or height counts as one, an
    // oversized width as the line RAM depth.
    always_comb begin
        if (r_fw == '0) begin
            w_eff = bbe_pkg::COL_W'(1);
        end else if (r_fw > bbe_pkg::COL_W'(bbe_pkg::MAX_WIDTH)) begin
            w_eff = bbe_pkg::COL_W'(bbe_pkg::MAX_WIDTH);
        end else begin
            w_eff = r_fw;
        end
        h_eff = (r_fh == '0) ? bbe_pkg::ROW_W'(1) : r_fh;
    end

    // Every result that may still arrive holds a queue slot, so a word is
    // taken only when the queue can absorb two more results.
    assign reserved = (bbe_pkg::FIFO_CNT_W + 1)'(fifo_cnt)
                    + (bbe_pkg::FIFO_CNT_W + 1)'(r_ctl_b.emit_a)
                    + (bbe_pkg::FIFO_CNT_W + 1)'(r_ctl_b.emit_b)
                    + (bbe_pkg::FIFO_CNT_W + 1)'(r_ctl_c.emit_a)
                    + (bbe_pkg::FIFO_CNT_W + 1)'(r_ctl_c.emit_b)
                    + (bbe_pkg::FIFO_CNT_W + 1)'(r_ctl_d.emit_a)
                    + (bbe_pkg::FIFO_CNT_W + 1)'(r_ctl_d.emit_b);
    assign i_pix.ready = (reserved <= (bbe_pkg::FIFO_CNT_W + 1)'(bbe_pkg::FIFO_DEPTH - 2));

    assign accept   = i_pix.valid & i_pix.ready;
    assign is_drain = (i_pix.cmd == bbe_pkg::CMD_DRAIN);
    assign pix_ok   = accept & !is_drain & (r_row < h_eff) & (r_col < w_eff);
    assign drn_ok   = accept & is_drain & (r_row >= h_eff) & (r_drn < w_eff);
    assign col_inc  = r_col + 1'b1;
    assign drn_inc  = r_drn + 1'b1;

    // Control word for the lanes: which sums enter each result and how many
    // pixels each mean divides by.
    always_comb begin
        n_ctl         = '0;
        n_ctl.pix     = pix_ok;
        n_ctl.drn     = drn_ok;
        n_ctl.hge2    = (h_eff >= bbe_pkg::ROW_W'(2));
        n_ctl.c_ge1   = (r_col != '0);
        n_ctl.c_ge2   = (r_col >= bbe_pkg::COL_W'(2));
        n_ctl.cap0    = (r_col == '0);
        n_ctl.d_first = (r_drn == '0);
        n_ctl.d_ge1   = (r_drn != '0);
        n_ctl.d_next  = (drn_inc < w_eff);
        rows_p = (r_row >= bbe_pkg::ROW_W'(2)) ? 2'd3 : 2'd2;
        cols_a = n_ctl.c_ge2 ? 2'd3 : 2'd2;
        cols_b = n_ctl.c_ge1 ? 2'd2 : 2'd1;
        cols_d = 2'd1 + 2'(n_ctl.d_ge1) + 2'(n_ctl.d_next);
        rows_d = n_ctl.hge2 ? 2'd2 : 2'd1;
        if (drn_ok) begin
            n_ctl.use_top = n_ctl.hge2;
            n_ctl.use_bot = 1'b0;
            n_ctl.emit_a  = 1'b1;
            n_ctl.last_a  = (drn_inc == w_eff);
            n_ctl.n_a     = bbe_pkg::CNT_W'(cols_d) * bbe_pkg::CNT_W'(rows_d);
        end else begin
            n_ctl.use_top = (r_row >= bbe_pkg::ROW_W'(2));
            n_ctl.use_bot = 1'b1;
            n_ctl.emit_a  = pix_ok & (r_row != '0) & n_ctl.c_ge1;
            n_ctl.emit_b  = pix_ok & (r_row != '0) & (col_inc == w_eff);
            n_ctl.n_a     = bbe_pkg::CNT_W'(cols_a) * bbe_pkg::CNT_W'(rows_p);
            n_ctl.n_b     = bbe_pkg::CNT_W'(cols_b) * bbe_pkg::CNT_W'(rows_p);
        end
    end

    // Frame position. A size register write restarts the frame.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_drn = r_drn;
        if (i_cfg_we) begin
            n_col = '0;
            n_row = '0;
            n_drn = '0;
        end else if (pix_ok) begin
            if (col_inc >= w_eff) begin
                n_col = '0;
                n_row = r_row + 1'b1;
            end else begin
                n_col = col_inc;
            end
        end else if (drn_ok) begin
            if (drn_inc >= w_eff) begin
                n_col = '0;
                n_row = '0;
                n_drn = '0;
            end else begin
                n_drn = drn_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw    <= bbe_pkg::COL_W'(bbe_pkg::MAX_WIDTH);
            r_fh    <= bbe_pkg::ROW_W'(1);
            r_col   <= '0;
            r_row   <= '0;
            r_drn   <= '0;
            r_ctl_b <= '0;
            r_ctl_c <= '0;
            r_ctl_d <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bbe_pkg::CFG_FRAME_WIDTH:  r_fw <= i_cfg_data[bbe_pkg::COL_W-1:0];
                    bbe_pkg::CFG_FRAME_HEIGHT: r_fh <= i_cfg_data;
                    default:                   r_fh <= r_fh;
                endcase
            end
            r_col   <= n_col;
            r_row   <= n_row;
            r_drn   <= n_drn;
            r_ctl_b <= n_ctl;
            r_ctl_c <= r_ctl_b;
            r_ctl_d <= r_ctl_c;
        end
    end

    // Rows alternate between the two line RAMs by row parity. A pixel reads
    // the row two above from its own RAM before overwriting it, and the row
    // above from the other one. A drain tick reads the next column ahead.
    assign pix_in   = {i_pix.in_red, i_pix.in_green, i_pix.in_blue};
    assign ram_addr = is_drain ? drn_inc[bbe_pkg::ADDR_W-1:0] : r_col[bbe_pkg::ADDR_W-1:0];

    bbe_line_ram u_ram0 (
        .i_clk   (i_clk),
        .i_we    (pix_ok & !r_row[0]),
        .i_addr  (ram_addr),
        .i_wdata (pix_in),
        .o_rdata (rd0)
    );

    bbe_line_ram u_ram1 (
        .i_clk   (i_clk),
        .i_we    (pix_ok & r_row[0]),
        .i_addr  (ram_addr),
        .i_wdata (pix_in),
        .o_rdata (rd1)
    );

    always_ff @(posedge i_clk) begin
        r_bot_b <= pix_in;
        r_sel_b <= is_drain ? h_eff[0] : r_row[0];
    end

    assign top_b = r_sel_b ? rd1 : rd0;
    assign mid_b = r_sel_b ? rd0 : rd1;

    // One lane per color channel.
    for (genvar g = 0; g < 3; g++) begin : g_lane
        bbe_lane u_lane (
            .i_clk    (i_clk),
            .i_ctl_b  (r_ctl_b),
            .i_ctl_c  (r_ctl_c),
            .i_top    (top_b[(2 - g) * bbe_pkg::PIX_W +: bbe_pkg::PIX_W]),
            .i_mid    (mid_b[(2 - g) * bbe_pkg::PIX_W +: bbe_pkg::PIX_W]),
            .i_bot    (r_bot_b[(2 - g) * bbe_pkg::PIX_W +: bbe_pkg::PIX_W]),
            .o_mean_a (mean_a[g]),
            .o_mean_b (mean_b[g])
        );
    end

    // Merge the lane means into result words; the window result goes first.
    always_comb begin
        res_a.red       = mean_a[0];
        res_a.green     = mean_a[1];
        res_a.blue      = mean_a[2];
        res_a.frame_end = r_ctl_d.last_a;
        res_b.red       = mean_b[0];
        res_b.green     = mean_b[1];
        res_b.blue      = mean_b[2];
        res_b.frame_end = 1'b0;
    end

    bbe_out_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_a (r_ctl_d.emit_a),
        .i_data_a (res_a),
        .i_push_b (r_ctl_d.emit_b),
        .i_data_b (res_b),
        .o_count  (fifo_cnt),
        .o_pix    (o_pix)
    );

    `BBE_ASSERT_IMP(a_fifo_bound, i_clk, i_rst_n, 1'b1, fifo_cnt <= bbe_pkg::FIFO_CNT_W'(bbe_pkg::FIFO_DEPTH))
    `BBE_ASSERT_IMP(a_kind_excl, i_clk, i_rst_n, r_ctl_b.drn, !r_ctl_b.pix && !r_ctl_b.emit_b)
    `BBE_ASSERT_IMP(a_last_drain, i_clk, i_rst_n, r_ctl_d.last_a, r_ctl_d.drn && r_ctl_d.emit_a)
    `BBE_ASSERT_NXT(a_pix_stage, i_clk, i_rst_n, pix_ok, r_ctl_b.pix)

endmodule
`default_nettype wire

// ===== dv/box_blur_3x3_edge_aware_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Box blur 3x3 edge-aware testbench
// Streams frames of RGB pixels and drain ticks through the blur and compares
// every blurred word with a cycle-free predictor kept in a scoreboard class.
// ----------------------------------------------------------------------------
`default_nettype none

module box_blur_3x3_edge_aware_tb;

    localparam int  HALF_PERIOD = 4;
    localparam int  SETTLE      = 24;     // cycles to let in-flight work finish
    localparam int  CYCLE_LIMIT = 600000;
    localparam int  TARGET_WORDS = 800;

    // Scoreboard: predicts the blurred words and checks them in order.
    class blur_scoreboard;
        logic [bbe_pkg::RGB_W-1:0] older_row[bbe_pkg::MAX_WIDTH];
        logic [bbe_pkg::RGB_W-1:0] newer_row[bbe_pkg::MAX_WIDTH];
        logic [bbe_pkg::RGB_W-1:0] window[6];
        int unsigned      col, row, drain_col;
        logic [10:0]      width_reg;
        logic [15:0]      height_reg;
        int unsigned      acc_r, acc_g, acc_b, acc_n;
        bbe_pkg::t_res    expected_words[$];
        int               mismatches;
        int               results_checked;

        function new();
            foreach (window[k]) window[k] = '0;
            width_reg       = 11'd1024;
            height_reg      = 16'd1;
            col             = 0;
            row             = 0;
            drain_col       = 0;
            mismatches      = 0;
            results_checked = 0;
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0) return 1;
            if (width_reg > bbe_pkg::MAX_WIDTH) return bbe_pkg::MAX_WIDTH;
            return width_reg;
        endfunction

        function int unsigned eff_height();
            return (height_reg == 0) ? 1 : height_reg;
        endfunction

        // Any size write starts a new frame; the line stores are kept.
        function void write_reg(bbe_pkg::t_cfg_idx idx, logic [bbe_pkg::CFG_W-1:0] value);
            if (idx == bbe_pkg::CFG_FRAME_WIDTH) width_reg = value[10:0];
            else height_reg = value;
            col       = 0;
            row       = 0;
            drain_col = 0;
        endfunction

        function void clear_acc();
            acc_r = 0; acc_g = 0; acc_b = 0; acc_n = 0;
        endfunction

        function void add_px(logic [bbe_pkg::RGB_W-1:0] px);
            acc_r += px[23:16];
            acc_g += px[15:8];
            acc_b += px[7:0];
            acc_n += 1;
        endfunction

        function logic [bbe_pkg::PIX_W-1:0] rounded_mean(int unsigned s);
            return bbe_pkg::PIX_W'((2 * s + acc_n) / (2 * acc_n));
        endfunction

        function void push_mean(logic last);
            bbe_pkg::t_res w;
            w.red       = rounded_mean(acc_r);
            w.green     = rounded_mean(acc_g);
            w.blue      = rounded_mean(acc_b);
            w.frame_end = last;
            expected_words.push_back(w);
        endfunction

        // Notes one accepted input word and queues the words it causes.
        function void note_word(bbe_pkg::t_cmd cmd, logic [bbe_pkg::RGB_W-1:0] px);
            int unsigned w, h, lo, hi;
            logic [bbe_pkg::RGB_W-1:0] top, mid;
            bit top_ok;
            w = eff_width();
            h = eff_height();
            if (cmd == bbe_pkg::CMD_PIXEL) begin
                if (row >= h || col >= w) return;
                top_ok = (row >= 2);
                top = older_row[col];
                mid = newer_row[col];
                older_row[col] = mid;
                newer_row[col] = px;
                if (row >= 1) begin
                    // Window centered one column back.
                    if (col >= 1) begin
                        clear_acc();
                        for (int k = 0; k < ((col >= 2) ? 6 : 3); k++)
                            if (top_ok || (k % 3) != 0) add_px(window[k]);
                        if (top_ok) add_px(top);
                        add_px(mid);
                        add_px(px);
                        push_mean(1'b0);
                    end
                    // Last column of the row above, right edge clipped.
                    if (col == w - 1) begin
                        clear_acc();
                        if (col >= 1)
                            for (int k = 0; k < 3; k++)
                                if (top_ok || k != 0) add_px(window[k]);
                        if (top_ok) add_px(top);
                        add_px(mid);
                        add_px(px);
                        push_mean(1'b0);
                    end
                end
                window[3] = window[0];
                window[4] = window[1];
                window[5] = window[2];
                window[0] = top;
                window[1] = mid;
                window[2] = px;
                col++;
                if (col >= w) begin
                    col = 0;
                    row++;
                end
            end else begin
                if (row < h || drain_col >= w) return;
                lo = (drain_col >= 1) ? drain_col - 1 : 0;
                hi = (drain_col + 1 < w) ? drain_col + 1 : w - 1;
                clear_acc();
                for (int x = lo; x <= hi; x++) begin
                    if (h >= 2) add_px(older_row[x]);
                    add_px(newer_row[x]);
                end
                push_mean(drain_col == w - 1);
                drain_col++;
                if (drain_col >= w) begin
                    col       = 0;
                    row       = 0;
                    drain_col = 0;
                end
            end
        endfunction

        function void check_word(bbe_pkg::t_res got);
            bbe_pkg::t_res want;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected word r=%0d g=%0d b=%0d end=%0b",
                             got.red, got.green, got.blue, got.frame_end);
                return;
            end
            want = expected_words.pop_front();
            results_checked++;
            if (got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.frame_end !== want.frame_end) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: word %0d expected r=%0d g=%0d b=%0d end=%0b,",
                              " got r=%0d g=%0d b=%0d end=%0b"},
                             results_checked, want.red, want.green, want.blue,
                             want.frame_end, got.red, got.green, got.blue, got.frame_end);
            end
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic                      i_cfg_idx;
    logic [bbe_pkg::CFG_W-1:0] i_cfg_data;

    bbe_in_if  pix_in ();
    bbe_out_if pix_out ();

    box_blur_3x3_edge_aware dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_in.sink),
        .o_pix      (pix_out.source)
    );

    blur_scoreboard sb = new();

    int unsigned cycle_count = 0;
    int unsigned words_sent  = 0;    // words that the block acts on
    int unsigned frames_done = 0;
    int unsigned stall_left  = 0;
    bit          calm_sink   = 1'b0;

    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Mostly short gaps with the odd long one.
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // Pixel content leans on the channel extremes now and then.
    function automatic logic [bbe_pkg::PIX_W-1:0] pick_channel();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return bbe_pkg::PIX_W'($urandom);
        endcase
    endfunction

    // Timeout watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side backpressure. Stretches of calm (always ready) alternate with
    // stretches of random stalls so that stalls land on every phase.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_out.ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 299) == 0) calm_sink = ~calm_sink;
            if (stall_left > 0) begin
                pix_out.ready <= 1'b0;
                stall_left = stall_left - 1;
            end else begin
                pix_out.ready <= 1'b1;
                if (!calm_sink && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    // Outputs only move at the rising edge, so the middle of the cycle shows
    // exactly what the next rising edge will take.
    always @(negedge i_clk) begin
        bbe_pkg::t_res got;
        if (i_rst_n && pix_out.valid && pix_out.ready) begin
            got.red       = pix_out.out_red;
            got.green     = pix_out.out_green;
            got.blue      = pix_out.out_blue;
            got.frame_end = pix_out.frame_end;
            sb.check_word(got);
        end
    end

    // Sends one word after a random gap and returns at the rising edge where
    // it was accepted. The valid stays high if the next word follows at once.
    task automatic send_word(bbe_pkg::t_cmd cmd, logic [bbe_pkg::RGB_W-1:0] px, bit counts);
        int unsigned gap;
        bit          took;
        gap = pick_gap();
        if (gap > 0) begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_in.valid    <= 1'b1;
        pix_in.cmd      <= cmd;
        pix_in.in_red   <= px[23:16];
        pix_in.in_green <= px[15:8];
        pix_in.in_blue  <= px[7:0];
        do begin
            @(negedge i_clk);
            took = pix_in.ready;
            @(posedge i_clk);
        end while (!took);
        sb.note_word(cmd, px);
        if (counts) words_sent++;
    endtask

    task automatic send_pixel(bit counts);
        send_word(bbe_pkg::CMD_PIXEL, {pick_channel(), pick_channel(), pick_channel()},
                  counts);
    endtask

    // Drops valid and waits until every expected word has come out, then lets
    // the pipeline settle since ignored words cause no result to wait for.
    task automatic wait_idle();
        pix_in.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Register writes happen only with the block idle. The enable drops
    // before the task returns so that writes never share an edge.
    task automatic write_reg(bbe_pkg::t_cfg_idx idx, logic [bbe_pkg::CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.write_reg(idx, value);
        @(posedge i_clk);
    endtask

    // One full frame of pixels then drain ticks. With noise on, a drain tick
    // comes early (ignored) and a stray pixel follows the last row (ignored).
    task automatic run_frame(bit noise);
        int unsigned w, h, early_at;
        w = sb.eff_width();
        h = sb.eff_height();
        early_at = $urandom_range(0, w * h - 1);
        for (int unsigned i = 0; i < w * h; i++) begin
            if (noise && i == early_at) send_word(bbe_pkg::CMD_DRAIN, '0, 1'b0);
            send_pixel(1'b1);
        end
        if (noise) send_pixel(1'b0);
        for (int unsigned d = 0; d < w; d++)
            send_word(bbe_pkg::CMD_DRAIN, '0, 1'b1);
        frames_done++;
    endtask

    initial begin
        int unsigned rounds, stop_after;
        pix_in.valid    <= 1'b0;
        pix_in.cmd      <= bbe_pkg::CMD_PIXEL;
        pix_in.in_red   <= '0;
        pix_in.in_green <= '0;
        pix_in.in_blue  <= '0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= bbe_pkg::CFG_FRAME_WIDTH;
        i_cfg_data      <= '0;
        i_rst_n         <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE) @(posedge i_clk);

        // Directed: single pixel frame, the smallest frame that gives the
        // corner, edge and full windows, and a drain tick on an empty frame.
        write_reg(bbe_pkg::CFG_FRAME_WIDTH, 16'd1);
        write_reg(bbe_pkg::CFG_FRAME_HEIGHT, 16'd1);
        send_word(bbe_pkg::CMD_DRAIN, '0, 1'b0);
        run_frame(1'b0);
        wait_idle();
        write_reg(bbe_pkg::CFG_FRAME_WIDTH, 16'd3);
        write_reg(bbe_pkg::CFG_FRAME_HEIGHT, 16'd3);
        send_word(bbe_pkg::CMD_PIXEL, 24'hFFFFFF, 1'b1);
        send_word(bbe_pkg::CMD_PIXEL, 24'h000000, 1'b1);
        send_word(bbe_pkg::CMD_PIXEL, 24'hFF00FF, 1'b1);
        send_word(bbe_pkg::CMD_PIXEL, 24'h00FF00, 1'b1);
        send_word(bbe_pkg::CMD_PIXEL, 24'hFFFFFF, 1'b1);
        send_word(bbe_pkg::CMD_PIXEL, 24'h010101, 1'b1);
        send_word(bbe_pkg::CMD_PIXEL, 24'h808080, 1'b1);
        send_word(bbe_pkg::CMD_PIXEL, 24'h7F7F7F, 1'b1);
        send_word(bbe_pkg::CMD_PIXEL, 24'hFEFEFE, 1'b1);
        send_pixel(1'b0);
        for (int d = 0; d < 3; d++) send_word(bbe_pkg::CMD_DRAIN, '0, 1'b1);
        wait_idle();

        // Zero sizes fall back to one.
        write_reg(bbe_pkg::CFG_FRAME_WIDTH, 16'd0);
        write_reg(bbe_pkg::CFG_FRAME_HEIGHT, 16'd0);
        run_frame(1'b1);
        wait_idle();

        // Tallest setting: a few rows then abandon the frame by a rewrite.
        write_reg(bbe_pkg::CFG_FRAME_WIDTH, 16'd1);
        write_reg(bbe_pkg::CFG_FRAME_HEIGHT, 16'hFFFF);
        repeat (5) send_pixel(1'b1);
        wait_idle();

        // Widest setting: the register maximum clamps to the line length, so
        // a long first row gives no row end; the frame is then abandoned.
        write_reg(bbe_pkg::CFG_FRAME_WIDTH, 16'd2047);
        write_reg(bbe_pkg::CFG_FRAME_HEIGHT, 16'd2);
        repeat (40) send_pixel(1'b1);
        wait_idle();

        // Random frames, mostly small. Some are cut short by a size write and
        // some carry words that the block has to ignore.
        while (words_sent < TARGET_WORDS) begin
            wait_idle();
            if (sb.width_reg > 40 || $urandom_range(0, 3) != 0)
                write_reg(bbe_pkg::CFG_FRAME_WIDTH, ($urandom_range(0, 9) == 0) ?
                          16'($urandom_range(9, 40)) : 16'($urandom_range(1, 8)));
            write_reg(bbe_pkg::CFG_FRAME_HEIGHT, 16'($urandom_range(1, 6)));
            if ($urandom_range(0, 9) == 0) begin
                stop_after = $urandom_range(1, sb.eff_width() * sb.eff_height());
                for (int unsigned i = 0; i < stop_after; i++) send_pixel(1'b1);
            end else begin
                rounds = $urandom_range(1, 3);
                repeat (rounds) run_frame($urandom_range(0, 6) == 0);
            end
        end

        wait_idle();
        $display("Covered %0d frames, %0d input words and %0d blurred words checked,",
                 frames_done, words_sent, sb.results_checked);
        $display("with sizes from one pixel up to the clamped width and random backpressure.");
        if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d words never seen",
                     sb.mismatches, sb.expected_words.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== box_blur_3x3_edge_aware.f =====
+incdir+rtl
rtl/bbe_pkg.sv
rtl/bbe_if.sv
rtl/bbe_line_ram.sv
rtl/bbe_lane.sv
rtl/bbe_out_fifo.sv
rtl/box_blur_3x3_edge_aware.sv
dv/box_blur_3x3_edge_aware_tb.sv
